/* sv/gbn_pkg.sv */
package gbn_pkg;

  // Sequence numbers count modulo MAX_SEQUENCE + 1, which equals 2**SEQ_W.
  localparam int MAX_SEQUENCE = 7;
  localparam int PACKET_BYTES = 256;
  localparam int HDR_BYTES    = 7;
  localparam int ACK_LOOP_CAP = 7;
  localparam int RESEND_CAP   = 8;

  localparam int SEQ_W   = 3;
  localparam int CNT_W   = 4;
  localparam int BYTES_W = 9;
  localparam int STEP_W  = 4;

  typedef logic [SEQ_W-1:0]   seq_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [BYTES_W-1:0] bytes_t;
  typedef logic [STEP_W-1:0]  step_t;

  // Event kinds on the input channel.
  localparam logic [2:0] KIND_PACKET     = 3'd0;
  localparam logic [2:0] KIND_LINK_READY = 3'd1;
  localparam logic [2:0] KIND_FRAME      = 3'd2;
  localparam logic [2:0] KIND_DATA_TMO   = 3'd3;
  localparam logic [2:0] KIND_ACK_TMO    = 3'd4;

  // Received frame types.
  localparam logic [1:0] FT_DATA = 2'd0;

  // Result actions.
  typedef enum logic [2:0] {
    ACT_SEND_DATA  = 3'd0,
    ACT_SEND_ACK   = 3'd1,
    ACT_DELIVER    = 3'd2,
    ACT_STOP_TIMER = 3'd3,
    ACT_STATUS     = 3'd4
  } action_t;

  // State update performed by a microcode step.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SEND_NEW,
    OP_SET_LINK,
    OP_DELIVER,
    OP_ACK_ONE,
    OP_LOAD_NTS,
    OP_RESEND,
    OP_SEND_ACK
  } op_t;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_FULL,
    COND_BAD,
    COND_NO_MATCH,
    COND_ACK_DONE,
    COND_RESEND_DONE
  } cond_t;

  typedef struct packed {
    logic    emit;
    action_t act;
    op_t     op;
    cond_t   cond;
    step_t   target;
    logic    done;
  } ctrl_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       frame_good;
    logic [1:0] frame_type;
    seq_t       frame_seq;
    seq_t       frame_ack_num;
    bytes_t     frame_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    seq_t       seq_out;
    seq_t       ack_out;
    bytes_t     payload_bytes;
    logic       network_enable;
    logic       last;
  } out_item_t;

  // Microcode step addresses.
  localparam step_t ST_PKT_CHECK  = 4'd0;
  localparam step_t ST_PKT_SEND   = 4'd1;
  localparam step_t ST_LINK       = 4'd2;
  localparam step_t ST_FRM_CHECK  = 4'd3;
  localparam step_t ST_FRM_MATCH  = 4'd4;
  localparam step_t ST_FRM_DELIV  = 4'd5;
  localparam step_t ST_ACK_TEST   = 4'd6;
  localparam step_t ST_ACK_STOP   = 4'd7;
  localparam step_t ST_RS_LOAD    = 4'd8;
  localparam step_t ST_RS_TEST    = 4'd9;
  localparam step_t ST_RS_SEND    = 4'd10;
  localparam step_t ST_ACK_TMO    = 4'd11;
  localparam step_t ST_STATUS     = 4'd12;

  function automatic ctrl_word_t cw(logic emit, action_t act, op_t op, cond_t cond,
                                    step_t target, logic done);
    ctrl_word_t w;
    w.emit   = emit;
    w.act    = act;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  // The control store: one word per step.
  function automatic ctrl_word_t ucode(step_t pc);
    ctrl_word_t w;
    unique case (pc)
      ST_PKT_CHECK: w = cw(1'b0, ACT_STATUS, OP_NONE, COND_FULL, ST_STATUS, 1'b0);
      ST_PKT_SEND:  w = cw(1'b1, ACT_SEND_DATA, OP_SEND_NEW, COND_ALWAYS, ST_STATUS, 1'b0);
      ST_LINK:      w = cw(1'b0, ACT_STATUS, OP_SET_LINK, COND_ALWAYS, ST_STATUS, 1'b0);
      ST_FRM_CHECK: w = cw(1'b0, ACT_STATUS, OP_NONE, COND_BAD, ST_STATUS, 1'b0);
      ST_FRM_MATCH: w = cw(1'b0, ACT_STATUS, OP_NONE, COND_NO_MATCH, ST_ACK_TEST, 1'b0);
      ST_FRM_DELIV: w = cw(1'b1, ACT_DELIVER, OP_DELIVER, COND_NEVER, ST_STATUS, 1'b0);
      ST_ACK_TEST:  w = cw(1'b0, ACT_STATUS, OP_NONE, COND_ACK_DONE, ST_STATUS, 1'b0);
      ST_ACK_STOP:  w = cw(1'b1, ACT_STOP_TIMER, OP_ACK_ONE, COND_ALWAYS, ST_ACK_TEST, 1'b0);
      ST_RS_LOAD:   w = cw(1'b0, ACT_STATUS, OP_LOAD_NTS, COND_NEVER, ST_STATUS, 1'b0);
      ST_RS_TEST:   w = cw(1'b0, ACT_STATUS, OP_NONE, COND_RESEND_DONE, ST_STATUS, 1'b0);
      ST_RS_SEND:   w = cw(1'b1, ACT_SEND_DATA, OP_RESEND, COND_ALWAYS, ST_RS_TEST, 1'b0);
      ST_ACK_TMO:   w = cw(1'b1, ACT_SEND_ACK, OP_SEND_ACK, COND_ALWAYS, ST_STATUS, 1'b0);
      default:      w = cw(1'b1, ACT_STATUS, OP_NONE, COND_NEVER, ST_STATUS, 1'b1);
    endcase
    return w;
  endfunction

  // Entry point of the program for each event kind.
  function automatic step_t dispatch(logic [2:0] kind);
    step_t s;
    unique case (kind)
      KIND_PACKET:     s = ST_PKT_CHECK;
      KIND_LINK_READY: s = ST_LINK;
      KIND_FRAME:      s = ST_FRM_CHECK;
      KIND_DATA_TMO:   s = ST_RS_LOAD;
      KIND_ACK_TMO:    s = ST_ACK_TMO;
      default:         s = ST_STATUS;
    endcase
    return s;
  endfunction

  function automatic seq_t seq_inc(seq_t x);
    return (x >= SEQ_W'(MAX_SEQUENCE)) ? '0 : x + SEQ_W'(1);
  endfunction

  // True when b lies in the circular window [a, c).
  function automatic logic in_window(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b < c)) || ((a <= b) && (c < a)) || ((b < c) && (c < a));
  endfunction

endpackage

/* sv/go_back_n_link_control.sv */
// Go-back-N link control, sender and receiver sequencing for one link.
// Input channel (in_valid/in_ready/in_data) carries one event per transfer:
// a packet from above, link ready, a checked received frame, a data
// timeout or an ACK timeout. Output channel (out_valid/out_ready/out_data)
// carries the ordered commands that the event causes, one per transfer,
// always closing with a status result that has last set.
// A small microcode program runs each event after a dispatch, one control
// word per cycle unless an emitting step waits for the output register.
// The longest program is a received frame that delivers a payload
// and then retires seven frames (deliver, then a test and a stop per frame).
// Results leave through a single output register; the next event is
// accepted as soon as the status result has been written into it.
// When the receiver stalls, any step that emits a result waits until the
// output register is free, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all sequence state, the link-ready
// flag and the output valid flag; in_ready stays low while rst_n is low.
module go_back_n_link_control (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbn_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gbn_pkg::out_item_t   out_data
);

  // Sequencer control.
  logic                busy_r, busy_nxt;
  gbn_pkg::step_t      pc_r, pc_nxt;
  gbn_pkg::cnt_t       cnt_r, cnt_nxt;
  gbn_pkg::in_item_t   ev_r;

  // Link state.
  gbn_pkg::seq_t       nts_r, nts_nxt;
  gbn_pkg::seq_t       ef_r, ef_nxt;
  gbn_pkg::seq_t       oldest_r, oldest_nxt;
  gbn_pkg::cnt_t       flight_r, flight_nxt;
  logic                link_r, link_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  gbn_pkg::out_item_t  out_data_r;
  gbn_pkg::out_item_t  res;

  gbn_pkg::ctrl_word_t word;
  logic                out_free;
  logic                go;
  logic                jump;
  logic                accept;
  gbn_pkg::bytes_t     pl;

  assign word     = gbn_pkg::ucode(pc_r);
  assign out_free = !out_valid_r || out_ready;
  assign go       = busy_r && (!word.emit || out_free);
  assign accept   = in_valid && in_ready;
  assign in_ready = rst_n && !busy_r;

  // Jump condition evaluation.
  always_comb begin
    unique case (word.cond)
      gbn_pkg::COND_NEVER:    jump = 1'b0;
      gbn_pkg::COND_ALWAYS:   jump = 1'b1;
      gbn_pkg::COND_FULL:     jump = flight_r >= gbn_pkg::CNT_W'(gbn_pkg::MAX_SEQUENCE);
      gbn_pkg::COND_BAD:      jump = !ev_r.frame_good;
      gbn_pkg::COND_NO_MATCH: jump = !((ev_r.frame_type == gbn_pkg::FT_DATA) &&
                                       (ev_r.frame_seq == ef_r));
      gbn_pkg::COND_ACK_DONE: jump = (flight_r == '0) ||
                                     !gbn_pkg::in_window(oldest_r, ev_r.frame_ack_num, nts_r) ||
                                     (cnt_r == gbn_pkg::CNT_W'(gbn_pkg::ACK_LOOP_CAP));
      gbn_pkg::COND_RESEND_DONE: jump = (cnt_r == gbn_pkg::CNT_W'(gbn_pkg::RESEND_CAP)) ||
                                        (cnt_r >= flight_r);
      default:                jump = 1'b0;
    endcase
  end

  // Delivered length: frame length less the header, clamped at both ends.
  always_comb begin
    if (ev_r.frame_bytes < gbn_pkg::BYTES_W'(gbn_pkg::HDR_BYTES)) begin
      pl = '0;
    end else if (ev_r.frame_bytes - gbn_pkg::BYTES_W'(gbn_pkg::HDR_BYTES) >
                 gbn_pkg::BYTES_W'(gbn_pkg::PACKET_BYTES)) begin
      pl = gbn_pkg::BYTES_W'(gbn_pkg::PACKET_BYTES);
    end else begin
      pl = ev_r.frame_bytes - gbn_pkg::BYTES_W'(gbn_pkg::HDR_BYTES);
    end
  end

  // Result built from the state before this step's update.
  always_comb begin
    res        = '0;
    res.action = word.act;
    unique case (word.act)
      gbn_pkg::ACT_SEND_DATA: begin
        res.seq_out = nts_r;
        res.ack_out = ef_r + gbn_pkg::SEQ_W'(gbn_pkg::MAX_SEQUENCE);
      end
      gbn_pkg::ACT_SEND_ACK: begin
        res.ack_out = ef_r + gbn_pkg::SEQ_W'(gbn_pkg::MAX_SEQUENCE);
      end
      gbn_pkg::ACT_DELIVER: begin
        res.payload_bytes = pl;
      end
      gbn_pkg::ACT_STOP_TIMER: begin
        res.seq_out = oldest_r;
      end
      gbn_pkg::ACT_STATUS: begin
        res.network_enable = (flight_r < gbn_pkg::CNT_W'(gbn_pkg::MAX_SEQUENCE)) && link_r;
        res.last           = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    busy_nxt   = busy_r;
    pc_nxt     = pc_r;
    cnt_nxt    = cnt_r;
    nts_nxt    = nts_r;
    ef_nxt     = ef_r;
    oldest_nxt = oldest_r;
    flight_nxt = flight_r;
    link_nxt   = link_r;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = gbn_pkg::dispatch(in_data.kind);
      cnt_nxt  = '0;
    end else if (go) begin
      if (word.done) begin
        busy_nxt = 1'b0;
      end else if (jump) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + gbn_pkg::STEP_W'(1);
      end
      unique case (word.op)
        gbn_pkg::OP_NONE: begin
        end
        gbn_pkg::OP_SEND_NEW: begin
          flight_nxt = flight_r + gbn_pkg::CNT_W'(1);
          link_nxt   = 1'b0;
          nts_nxt    = gbn_pkg::seq_inc(nts_r);
        end
        gbn_pkg::OP_SET_LINK: begin
          link_nxt = 1'b1;
        end
        gbn_pkg::OP_DELIVER: begin
          ef_nxt = gbn_pkg::seq_inc(ef_r);
        end
        gbn_pkg::OP_ACK_ONE: begin
          flight_nxt = flight_r - gbn_pkg::CNT_W'(1);
          oldest_nxt = gbn_pkg::seq_inc(oldest_r);
          cnt_nxt    = cnt_r + gbn_pkg::CNT_W'(1);
        end
        gbn_pkg::OP_LOAD_NTS: begin
          nts_nxt = oldest_r;
        end
        gbn_pkg::OP_RESEND: begin
          link_nxt = 1'b0;
          nts_nxt  = gbn_pkg::seq_inc(nts_r);
          cnt_nxt  = cnt_r + gbn_pkg::CNT_W'(1);
        end
        gbn_pkg::OP_SEND_ACK: begin
          link_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register valid: loaded by an emitting step, freed by a transfer.
  always_comb begin
    if (go && word.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= gbn_pkg::ST_STATUS;
      cnt_r       <= '0;
      nts_r       <= '0;
      ef_r        <= '0;
      oldest_r    <= '0;
      flight_r    <= '0;
      link_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      nts_r       <= nts_nxt;
      ef_r        <= ef_nxt;
      oldest_r    <= oldest_nxt;
      flight_r    <= flight_nxt;
      link_r      <= link_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r <= in_data;
    end
    if (go && word.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/gbn_checker.sv */
module gbn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input gbn_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input gbn_pkg::out_item_t out_data
);

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // A waiting event stays offered with the same contents.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> (in_valid && $stable(in_data)))
    else $error("event changed while waiting");

  // An accepted event blocks the next one until its program has finished.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second event accepted while busy");

  // Only the status result closes an event.
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.action == gbn_pkg::ACT_STATUS)))
    else $error("last flag does not match status action");

  // Network enable appears on status results only.
  a_enable_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.action != gbn_pkg::ACT_STATUS)) |-> !out_data.network_enable)
    else $error("network enable on a non-status result");

endmodule

bind go_back_n_link_control gbn_checker u_gbn_checker (.*);

/* tb/tb_go_back_n_link_control.sv */
`timescale 1ns / 1ps

module tb_go_back_n_link_control;

  // Frame types and event kinds that the package leaves unnamed.
  localparam logic [1:0] FT_ACK      = 2'd1;
  localparam logic [1:0] FT_OTHER    = 2'd2;
  localparam logic [1:0] FT_RESERVED = 2'd3;
  localparam logic [2:0] KIND_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN_HI = 3'd7;

  localparam int RANDOM_EVENTS  = 305;
  localparam int HOLD_AT_RESULT = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 1_000_000;

  // Sequencing state of one link, as the block should hold it.
  typedef struct {
    gbn_pkg::seq_t next_seq;
    gbn_pkg::seq_t expected;
    gbn_pkg::seq_t oldest;
    gbn_pkg::cnt_t in_flight;
    logic          link_ready;
  } link_state_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  gbn_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  gbn_pkg::out_item_t out_data;

  gbn_pkg::in_item_t  event_q[$];
  gbn_pkg::out_item_t expected_q[$];
  link_state_t plan_state = '{default: '0};
  link_state_t track_state = '{default: '0};
  int unsigned idle_left = 0;
  int unsigned stall_left = 0;
  int unsigned events_sent = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_done = 1'b0;

  go_back_n_link_control u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic gbn_pkg::out_item_t command(gbn_pkg::action_t act, gbn_pkg::seq_t seq,
                                                 gbn_pkg::seq_t ack, gbn_pkg::bytes_t len,
                                                 logic en, logic fin);
    gbn_pkg::out_item_t c;
    c.action         = act;
    c.seq_out        = seq;
    c.ack_out        = ack;
    c.payload_bytes  = len;
    c.network_enable = en;
    c.last           = fin;
    return c;
  endfunction

  // Computes the commands one event causes and advances the link state.
  function automatic void link_commands(ref link_state_t s, input gbn_pkg::in_item_t ev,
                                        ref gbn_pkg::out_item_t cmds[$]);
    int len;
    int steps;
    case (ev.kind)
      gbn_pkg::KIND_PACKET: begin
        // A new packet goes out only while the window has room.
        if (s.in_flight < gbn_pkg::cnt_t'(gbn_pkg::MAX_SEQUENCE)) begin
          s.in_flight = s.in_flight + 1'b1;
          cmds.push_back(command(gbn_pkg::ACT_SEND_DATA, s.next_seq,
                                 gbn_pkg::seq_t'(s.expected - 1'b1), '0, 1'b0, 1'b0));
          s.link_ready = 1'b0;
          s.next_seq = s.next_seq + 1'b1;
        end
      end
      gbn_pkg::KIND_LINK_READY: begin
        s.link_ready = 1'b1;
      end
      gbn_pkg::KIND_FRAME: begin
        if (ev.frame_good) begin
          // An in-order data frame is delivered, with its length clamped.
          if (ev.frame_type == gbn_pkg::FT_DATA && ev.frame_seq == s.expected) begin
            len = (ev.frame_bytes < gbn_pkg::bytes_t'(gbn_pkg::HDR_BYTES)) ? 0 :
                  int'(ev.frame_bytes) - gbn_pkg::HDR_BYTES;
            if (len > gbn_pkg::PACKET_BYTES) len = gbn_pkg::PACKET_BYTES;
            cmds.push_back(command(gbn_pkg::ACT_DELIVER, '0, '0, gbn_pkg::bytes_t'(len),
                                   1'b0, 1'b0));
            s.expected = s.expected + 1'b1;
          end
          // Retire every outstanding frame up to and including the ack.
          steps = 0;
          while (steps < gbn_pkg::ACK_LOOP_CAP && s.in_flight != 0 &&
                 gbn_pkg::seq_t'(ev.frame_ack_num - s.oldest) <
                 gbn_pkg::seq_t'(s.next_seq - s.oldest)) begin
            s.in_flight = s.in_flight - 1'b1;
            cmds.push_back(command(gbn_pkg::ACT_STOP_TIMER, s.oldest, '0, '0, 1'b0, 1'b0));
            s.oldest = s.oldest + 1'b1;
            steps++;
          end
        end
      end
      gbn_pkg::KIND_DATA_TMO: begin
        // Go back to the oldest frame and send the whole window again.
        s.next_seq = s.oldest;
        for (steps = 0; steps < gbn_pkg::RESEND_CAP && steps < int'(s.in_flight);
             steps++) begin
          cmds.push_back(command(gbn_pkg::ACT_SEND_DATA, s.next_seq,
                                 gbn_pkg::seq_t'(s.expected - 1'b1), '0, 1'b0, 1'b0));
          s.link_ready = 1'b0;
          s.next_seq = s.next_seq + 1'b1;
        end
      end
      gbn_pkg::KIND_ACK_TMO: begin
        cmds.push_back(command(gbn_pkg::ACT_SEND_ACK, '0, gbn_pkg::seq_t'(s.expected - 1'b1),
                               '0, 1'b0, 1'b0));
        s.link_ready = 1'b0;
      end
      default: begin
      end
    endcase
    cmds.push_back(command(gbn_pkg::ACT_STATUS, '0, '0, '0,
                           (s.in_flight < gbn_pkg::cnt_t'(gbn_pkg::MAX_SEQUENCE)) &&
                           s.link_ready, 1'b1));
  endfunction

  // Queues one event and keeps the planning copy of the state in step.
  task automatic post_event(input logic [2:0] kind, input logic good, input logic [1:0] ftype,
                            input gbn_pkg::seq_t fseq, input gbn_pkg::seq_t fack,
                            input gbn_pkg::bytes_t fbytes);
    gbn_pkg::in_item_t  ev;
    gbn_pkg::out_item_t scratch[$];
    ev.kind          = kind;
    ev.frame_good    = good;
    ev.frame_type    = ftype;
    ev.frame_seq     = fseq;
    ev.frame_ack_num = fack;
    ev.frame_bytes   = fbytes;
    event_q.push_back(ev);
    link_commands(plan_state, ev, scratch);
  endtask

  // Mostly back-to-back, now and then a short pause, rarely a long one.
  function automatic int unsigned draw_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: offers queued events and predicts each one on its transfer.
  always @(posedge clk) begin : drive
    int unsigned gap;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left <= 0;
    end else if (in_valid && in_ready) begin
      link_commands(track_state, in_data, expected_q);
      events_sent++;
      gap = draw_gap(events_sent >= 120 && events_sent < 170);
      if (gap == 0 && event_q.size() != 0) begin
        in_data <= event_q.pop_front();
      end else begin
        in_valid  <= 1'b0;
        idle_left <= gap;
      end
    end else if (!in_valid) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
      end else if (event_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= event_q.pop_front();
      end
    end
  end

  // Monitor: checks each result transfer and paces out_ready.
  always @(posedge clk) begin : watch
    gbn_pkg::out_item_t want;
    int unsigned        gap;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: action %0d with nothing pending", out_data.action);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("action", 32'(want.action), 32'(out_data.action));
        check_field("seq_out", 32'(want.seq_out), 32'(out_data.seq_out));
        check_field("ack_out", 32'(want.ack_out), 32'(out_data.ack_out));
        check_field("payload_bytes", 32'(want.payload_bytes), 32'(out_data.payload_bytes));
        check_field("network_enable", 32'(want.network_enable),
                    32'(out_data.network_enable));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
      results_seen++;
      // One long hold-off lets the block back up into its input.
      if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = draw_gap(results_seen >= 400 && results_seen < 480);
      end
      out_ready  <= (gap == 0);
      stall_left <= gap;
    end else if (stall_left != 0) begin
      out_ready  <= (stall_left == 1);
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned     roll;
    logic [2:0]      kind;
    logic            good;
    logic [1:0]      ftype;
    gbn_pkg::seq_t   fseq;
    gbn_pkg::seq_t   fack;
    gbn_pkg::bytes_t fbytes;

    // Unknown kinds only report status.
    post_event(KIND_UNKNOWN_LO, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    post_event(KIND_UNKNOWN_HI, 1'b1, FT_RESERVED, 3'd7, 3'd7, 9'd511);
    post_event(gbn_pkg::KIND_LINK_READY, 1'b1, FT_RESERVED, 3'd7, 3'd7, 9'd511);
    // Fill the window, then offer packets that must be dropped.
    repeat (gbn_pkg::MAX_SEQUENCE) begin
      post_event(gbn_pkg::KIND_PACKET, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    end
    post_event(gbn_pkg::KIND_PACKET, 1'b1, FT_ACK, 3'd5, 3'd2, 9'd100);
    post_event(gbn_pkg::KIND_LINK_READY, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    post_event(gbn_pkg::KIND_PACKET, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    // Resend the full window, then send a bare ack.
    post_event(gbn_pkg::KIND_DATA_TMO, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    post_event(gbn_pkg::KIND_ACK_TMO, 1'b1, FT_OTHER, 3'd3, 3'd4, 9'd200);
    // Deliver with an oversized length and retire all seven frames at once.
    post_event(gbn_pkg::KIND_FRAME, 1'b1, gbn_pkg::FT_DATA, 3'd0, 3'd6, 9'd511);
    // A bad frame is ignored apart from status.
    post_event(gbn_pkg::KIND_FRAME, 1'b0, gbn_pkg::FT_DATA, 3'd1, 3'd7, 9'd511);
    // Short frame, exact maximum length and an empty payload.
    post_event(gbn_pkg::KIND_FRAME, 1'b1, gbn_pkg::FT_DATA, 3'd1, 3'd0, 9'd3);
    post_event(gbn_pkg::KIND_FRAME, 1'b1, gbn_pkg::FT_DATA, 3'd2, 3'd0, 9'd263);
    post_event(gbn_pkg::KIND_FRAME, 1'b1, gbn_pkg::FT_DATA, 3'd3, 3'd0, 9'd7);
    // Two frames in flight across the wrap, acked by non-data frames.
    post_event(gbn_pkg::KIND_LINK_READY, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    post_event(gbn_pkg::KIND_PACKET, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    post_event(gbn_pkg::KIND_PACKET, 1'b0, gbn_pkg::FT_DATA, 3'd0, 3'd0, 9'd0);
    post_event(gbn_pkg::KIND_FRAME, 1'b1, FT_RESERVED, 3'd4, 3'd0, 9'd50);
    post_event(gbn_pkg::KIND_FRAME, 1'b1, FT_OTHER, 3'd4, 3'd5, 9'd50);
    post_event(gbn_pkg::KIND_FRAME, 1'b1, FT_ACK, 3'd4, 3'd3, 9'd50);

    // Random traffic, shaped so that most frames are in order and ack
    // something in the window.
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      roll   = $urandom_range(0, 99);
      good   = 1'($urandom_range(0, 1));
      ftype  = 2'($urandom_range(0, 3));
      fseq   = gbn_pkg::seq_t'($urandom);
      fack   = gbn_pkg::seq_t'($urandom);
      fbytes = gbn_pkg::bytes_t'($urandom_range(0, 511));
      if (roll < 30) begin
        kind = gbn_pkg::KIND_PACKET;
      end else if (roll < 42) begin
        kind = gbn_pkg::KIND_LINK_READY;
      end else if (roll < 80) begin
        kind = gbn_pkg::KIND_FRAME;
        good = ($urandom_range(0, 99) < 88);
        roll = $urandom_range(0, 99);
        ftype = (roll < 60) ? gbn_pkg::FT_DATA : (roll < 85) ? FT_ACK :
                (roll < 93) ? FT_OTHER : FT_RESERVED;
        if ($urandom_range(0, 99) < 75) fseq = plan_state.expected;
        if (plan_state.in_flight != 0 && $urandom_range(0, 99) < 65) begin
          fack = plan_state.oldest +
                 gbn_pkg::seq_t'($urandom_range(0, int'(plan_state.in_flight) - 1));
        end
        roll = $urandom_range(0, 99);
        fbytes = (roll < 80) ? gbn_pkg::bytes_t'($urandom_range(7, 263)) :
                 (roll < 90) ? gbn_pkg::bytes_t'($urandom_range(0, 6)) :
                 gbn_pkg::bytes_t'($urandom_range(264, 511));
      end else if (roll < 88) begin
        kind = gbn_pkg::KIND_DATA_TMO;
      end else if (roll < 95) begin
        kind = gbn_pkg::KIND_ACK_TMO;
      end else begin
        kind = 3'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
      end
      post_event(kind, good, ftype, fseq, fack, fbytes);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every event to transfer and every result to arrive.
    while (event_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
    end
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
